### rtl/sar_offset_trim_calibrator_unit_defines.svh
// assertion macros used by the calibrator top level
`ifndef SAR_OFFSET_TRIM_CALIBRATOR_UNIT_DEFINES_SVH
`define SAR_OFFSET_TRIM_CALIBRATOR_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SOTC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sotc same-cycle check failed");

// next-cycle implication, checked out of reset
`define SOTC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sotc next-cycle check failed");

`endif

### rtl/sotc_pkg.sv
// types, constants and codes of the offset trim calibrator
package sotc_pkg;

  localparam int CHANNELS  = 4;
  localparam int TRIM_BITS = 5;
  localparam int CMP_W     = 4;
  localparam int STEP_W    = TRIM_BITS - 1;
  localparam int PHASE_W   = 3;

  localparam logic [TRIM_BITS-1:0] TRIM_MID   = TRIM_BITS'(1) << (TRIM_BITS - 1);
  localparam logic [TRIM_BITS-1:0] TRIM_MAX   = {TRIM_BITS{1'b1}};
  localparam logic [STEP_W-1:0]    STEP_START = STEP_W'(1) << (STEP_W - 1);

  localparam logic [PHASE_W-1:0] PH_IDLE    = 3'd0;
  localparam logic [PHASE_W-1:0] PH_NSEARCH = 3'd1;
  localparam logic [PHASE_W-1:0] PH_NCHECK  = 3'd2;
  localparam logic [PHASE_W-1:0] PH_PSEARCH = 3'd3;
  localparam logic [PHASE_W-1:0] PH_PCHECK  = 3'd4;

  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_COMPARE = 1'b1;

  typedef logic [CHANNELS-1:0][TRIM_BITS-1:0] trim_arr_t;

  typedef struct packed {
    logic             command;
    logic [CMP_W-1:0] comparator_bits;
    logic             all_ready;
  } item_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [STEP_W-1:0]  step;
    trim_arr_t          n_trims;
    trim_arr_t          p_trims;
  } cal_state_t;

  typedef struct packed {
    logic done;
    logic err;
  } flags_t;

endpackage

### rtl/sar_offset_trim_calibrator_unit.sv
// top level of the offset trim calibrator: state, result register, glue
// an accepted beat passes the input register, then the result register
// throughput: one beat per cycle unless result_stall holds the result,
//   set by the state update between the input and the result register
// reset: rst clears the phase to idle, the step to zero and all trims to mid
//   scale, and empties both the input and the result register
`include "sar_offset_trim_calibrator_unit_defines.svh"

module sar_offset_trim_calibrator_unit
  import sotc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  logic                 command,
  input  logic [CMP_W-1:0]     comparator_bits,
  input  logic                 all_ready,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic [PHASE_W-1:0]   phase,
  output logic [TRIM_BITS-1:0] trim_n_ch0,
  output logic [TRIM_BITS-1:0] trim_n_ch1,
  output logic [TRIM_BITS-1:0] trim_n_ch2,
  output logic [TRIM_BITS-1:0] trim_n_ch3,
  output logic [TRIM_BITS-1:0] trim_p_ch0,
  output logic [TRIM_BITS-1:0] trim_p_ch1,
  output logic [TRIM_BITS-1:0] trim_p_ch2,
  output logic [TRIM_BITS-1:0] trim_p_ch3,
  output logic                 done_res,
  output logic                 error
);

  logic       pend;
  logic       advance;
  item_t      item_q;
  cal_state_t st;
  cal_state_t st_next;
  flags_t     flags;
  trim_arr_t  res_n;
  trim_arr_t  res_p;

  assign advance = pend && (!result_valid || !result_stall);

  sotc_in_reg u_in_reg (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_valid),
    .item_stall      (item_stall),
    .command         (command),
    .comparator_bits (comparator_bits),
    .all_ready       (all_ready),
    .advance         (advance),
    .pend            (pend),
    .item_q          (item_q)
  );

  sotc_step u_step (
    .item    (item_q),
    .st      (st),
    .st_next (st_next),
    .flags   (flags)
  );

  // calibration state
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase <= PH_IDLE;
      st.step  <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        st.n_trims[i] <= TRIM_MID;
        st.p_trims[i] <= TRIM_MID;
      end
    end else if (advance) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      phase    <= st_next.phase;
      res_n    <= st_next.n_trims;
      res_p    <= st_next.p_trims;
      done_res <= flags.done;
      error    <= flags.err;
    end
  end

  assign trim_n_ch0 = res_n[0];
  assign trim_n_ch1 = res_n[1];
  assign trim_n_ch2 = res_n[2];
  assign trim_n_ch3 = res_n[3];
  assign trim_p_ch0 = res_p[0];
  assign trim_p_ch1 = res_p[1];
  assign trim_p_ch2 = res_p[2];
  assign trim_p_ch3 = res_p[3];

  `SOTC_ASSERT_NEXT(a_adv_loads_result, advance, result_valid)
  `SOTC_ASSERT_NOW(a_search_step_live, (st.phase == PH_NSEARCH || st.phase == PH_PSEARCH), st.step != '0)
  `SOTC_ASSERT_NOW(a_done_goes_idle, result_valid && done_res, phase == PH_IDLE)
  `SOTC_ASSERT_NOW(a_done_err_excl, result_valid, !(done_res && error))
  `SOTC_ASSERT_NOW(a_phase_range, 1'b1, st.phase <= PH_PCHECK)

endmodule

### rtl/sotc_in_reg.sv
// input register stage that holds one accepted beat
module sotc_in_reg
  import sotc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  logic             command,
  input  logic [CMP_W-1:0] comparator_bits,
  input  logic             all_ready,
  input  logic             advance,
  output logic             pend,
  output item_t            item_q
);

  logic take;

  assign item_stall = pend && !advance;
  assign take       = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (take) begin
      pend <= 1'b1;
    end else if (advance) begin
      pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_q.command         <= command;
      item_q.comparator_bits <= comparator_bits;
      item_q.all_ready       <= all_ready;
    end
  end

endmodule

### rtl/sotc_step.sv
// next-state logic for one beat: start check, search step and check step
module sotc_step
  import sotc_pkg::*;
(
  input  item_t      item,
  input  cal_state_t st,
  output cal_state_t st_next,
  output flags_t     flags
);

  logic [STEP_W-1:0]    step_half;
  logic [TRIM_BITS-1:0] step_ext;
  trim_arr_t            n_search;
  trim_arr_t            p_search;
  trim_arr_t            n_check;
  trim_arr_t            p_check;
  trim_arr_t            mid_arr;

  assign step_half = st.step >> 1;
  assign step_ext  = TRIM_BITS'(st.step);

  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      mid_arr[i] = TRIM_MID;
      if (i < CMP_W && item.comparator_bits[i % CMP_W]) begin
        n_search[i] = st.n_trims[i] + step_ext;
        p_search[i] = st.p_trims[i] + step_ext;
        n_check[i]  = (st.n_trims[i] != TRIM_MAX) ? st.n_trims[i] + TRIM_BITS'(1)
                                                  : st.n_trims[i];
        p_check[i]  = (st.p_trims[i] != TRIM_MAX) ? st.p_trims[i] + TRIM_BITS'(1)
                                                  : st.p_trims[i];
      end else begin
        n_search[i] = st.n_trims[i] - step_ext;
        p_search[i] = st.p_trims[i] - step_ext;
        n_check[i]  = st.n_trims[i];
        p_check[i]  = st.p_trims[i];
      end
    end
  end

  always_comb begin
    st_next    = st;
    flags.done = 1'b0;
    flags.err  = 1'b0;
    if (item.command == CMD_START) begin
      if (st.phase != PH_IDLE || !item.all_ready) begin
        flags.err = 1'b1;
      end else begin
        st_next.n_trims = mid_arr;
        st_next.step    = STEP_START;
        st_next.phase   = PH_NSEARCH;
      end
    end else begin
      case (st.phase)
        PH_NSEARCH: begin
          st_next.n_trims = n_search;
          st_next.step    = step_half;
          if (step_half == '0) st_next.phase = PH_NCHECK;
        end
        PH_NCHECK: begin
          st_next.n_trims = n_check;
          st_next.p_trims = mid_arr;
          st_next.step    = STEP_START;
          st_next.phase   = PH_PSEARCH;
        end
        PH_PSEARCH: begin
          st_next.p_trims = p_search;
          st_next.step    = step_half;
          if (step_half == '0) st_next.phase = PH_PCHECK;
        end
        PH_PCHECK: begin
          st_next.p_trims = p_check;
          st_next.phase   = PH_IDLE;
          flags.done      = 1'b1;
        end
        default: begin
          st_next.phase = PH_IDLE;
        end
      endcase
    end
  end

endmodule

### sim/tb_sar_offset_trim_calibrator_unit.sv
// testbench for the offset trim calibrator: trim predictor, scoreboard class, beat drivers
module tb_sar_offset_trim_calibrator_unit;
  import sotc_pkg::*;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    trim_arr_t          n_trims;
    trim_arr_t          p_trims;
    logic               done;
    logic               err;
  } cal_result_t;

  class trim_scoreboard;
    cal_result_t pending[$];
    int unsigned fails;
    int unsigned checked;
    int unsigned done_seen;
    int unsigned err_seen;

    function void note_beat(cal_result_t want);
      pending.push_back(want);
    endfunction

    task report(string what);
      $display("%0t mismatch: %s", $realtime, what);
      fails++;
    endtask

    task check_beat(cal_result_t got);
      cal_result_t want;
      if (pending.size() == 0) begin
        report("result beat with no prediction waiting");
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.done) done_seen++;
      if (got.err) err_seen++;
      if (got.phase !== want.phase)
        report($sformatf("phase got %0d want %0d", got.phase, want.phase));
      for (int ch = 0; ch < CHANNELS; ch++) begin
        if (got.n_trims[ch] !== want.n_trims[ch])
          report($sformatf("trim_n ch%0d got %0d want %0d", ch, got.n_trims[ch],
                           want.n_trims[ch]));
        if (got.p_trims[ch] !== want.p_trims[ch])
          report($sformatf("trim_p ch%0d got %0d want %0d", ch, got.p_trims[ch],
                           want.p_trims[ch]));
      end
      if (got.done !== want.done)
        report($sformatf("done_res got %0b want %0b", got.done, want.done));
      if (got.err !== want.err)
        report($sformatf("error got %0b want %0b", got.err, want.err));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid;
  logic item_stall;
  logic command;
  logic [CMP_W-1:0] comparator_bits;
  logic all_ready;
  logic result_valid;
  logic result_stall;
  logic [PHASE_W-1:0] phase;
  logic [TRIM_BITS-1:0] trim_n_ch0, trim_n_ch1, trim_n_ch2, trim_n_ch3;
  logic [TRIM_BITS-1:0] trim_p_ch0, trim_p_ch1, trim_p_ch2, trim_p_ch3;
  logic done_res;
  logic error;

  trim_scoreboard sb = new();

  // predictor state
  logic [PHASE_W-1:0] cal_phase;
  logic [STEP_W-1:0]  cal_step;
  trim_arr_t          cal_n;
  trim_arr_t          cal_p;

  bit hold_req;
  int unsigned burst_left;
  int unsigned fast_left;
  int unsigned items_sent;

  sar_offset_trim_calibrator_unit dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall),
    .command(command), .comparator_bits(comparator_bits), .all_ready(all_ready),
    .result_valid(result_valid), .result_stall(result_stall),
    .phase(phase),
    .trim_n_ch0(trim_n_ch0), .trim_n_ch1(trim_n_ch1),
    .trim_n_ch2(trim_n_ch2), .trim_n_ch3(trim_n_ch3),
    .trim_p_ch0(trim_p_ch0), .trim_p_ch1(trim_p_ch1),
    .trim_p_ch2(trim_p_ch2), .trim_p_ch3(trim_p_ch3),
    .done_res(done_res), .error(error)
  );

  always #10 clk = ~clk;

  function automatic trim_arr_t search_trims(trim_arr_t t, logic [CMP_W-1:0] bits);
    for (int ch = 0; ch < CHANNELS; ch++) begin
      if (bits[ch]) t[ch] = t[ch] + TRIM_BITS'(cal_step);
      else t[ch] = t[ch] - TRIM_BITS'(cal_step);
    end
    return t;
  endfunction

  function automatic trim_arr_t check_trims(trim_arr_t t, logic [CMP_W-1:0] bits);
    for (int ch = 0; ch < CHANNELS; ch++)
      if (bits[ch] && t[ch] != TRIM_MAX) t[ch] = t[ch] + TRIM_BITS'(1);
    return t;
  endfunction

  function automatic cal_result_t predict_beat(logic cmd, logic [CMP_W-1:0] bits,
                                               logic ready);
    cal_result_t r;
    r.done = 1'b0;
    r.err = 1'b0;
    if (cmd == CMD_START) begin
      if (cal_phase != PH_IDLE || !ready) begin
        r.err = 1'b1;
      end else begin
        cal_n = {CHANNELS{TRIM_MID}};
        cal_step = STEP_START;
        cal_phase = PH_NSEARCH;
      end
    end else begin
      case (cal_phase)
        PH_NSEARCH: begin
          cal_n = search_trims(cal_n, bits);
          cal_step = cal_step >> 1;
          if (cal_step == '0) cal_phase = PH_NCHECK;
        end
        PH_NCHECK: begin
          cal_n = check_trims(cal_n, bits);
          cal_p = {CHANNELS{TRIM_MID}};
          cal_step = STEP_START;
          cal_phase = PH_PSEARCH;
        end
        PH_PSEARCH: begin
          cal_p = search_trims(cal_p, bits);
          cal_step = cal_step >> 1;
          if (cal_step == '0) cal_phase = PH_PCHECK;
        end
        PH_PCHECK: begin
          cal_p = check_trims(cal_p, bits);
          cal_phase = PH_IDLE;
          r.done = 1'b1;
        end
        default: cal_phase = PH_IDLE;
      endcase
    end
    r.phase = cal_phase;
    r.n_trims = cal_n;
    r.p_trims = cal_p;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst && item_valid && !item_stall)
      sb.note_beat(predict_beat(command, comparator_bits, all_ready));
  end

  always @(posedge clk) begin : result_mon
    cal_result_t got;
    if (!rst && result_valid && !result_stall) begin
      got.phase = phase;
      got.n_trims = {trim_n_ch3, trim_n_ch2, trim_n_ch1, trim_n_ch0};
      got.p_trims = {trim_p_ch3, trim_p_ch2, trim_p_ch1, trim_p_ch0};
      got.done = done_res;
      got.err = error;
      sb.check_beat(got);
    end
  end

  // receiver stall pattern, with a long hold-off on request
  initial begin : rx_stall
    int mode;
    int left;
    mode = 0;
    left = 0;
    result_stall <= 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        result_stall <= 1'b1;
        repeat (80) @(posedge clk);
        result_stall <= 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(30, 200);
        end
        left--;
        case (mode)
          0: result_stall <= 1'b0;
          1: result_stall <= ($urandom_range(0, 9) < 3);
          2: result_stall <= (left % 4 == 0);
          default: result_stall <= ($urandom_range(0, 9) < 7);
        endcase
      end
    end
  end

  task automatic send_beat(logic cmd, logic [CMP_W-1:0] bits, logic ready);
    int unsigned gap;
    item_valid <= 1'b1;
    command <= cmd;
    comparator_bits <= bits;
    all_ready <= ready;
    do @(posedge clk); while (item_stall);
    items_sent++;
    if (fast_left > 0) fast_left--;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0 || fast_left > 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  function automatic logic [CMP_W-1:0] pick_bits();
    case ($urandom_range(0, 7))
      0: return '1;
      1: return '0;
      default: return CMP_W'($urandom);
    endcase
  endfunction

  task automatic run_calibration();
    send_beat(CMD_START, pick_bits(), 1'b1);
    for (int k = 0; k < 10; k++) begin
      if ($urandom_range(0, 19) == 0)
        send_beat(CMD_START, pick_bits(), 1'($urandom));
      send_beat(CMD_COMPARE, pick_bits(), 1'($urandom));
    end
  endtask

  // wait past the edge so the last accepted beat is already noted
  task automatic drain_results();
    item_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin
    #4_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    bit held;
    bit drained;
    item_valid <= 1'b0;
    command <= CMD_START;
    comparator_bits <= '0;
    all_ready <= 1'b0;
    cal_phase = PH_IDLE;
    cal_step = '0;
    cal_n = {CHANNELS{TRIM_MID}};
    cal_p = {CHANNELS{TRIM_MID}};
    hold_req = 1'b0;
    burst_left = 0;
    fast_left = 0;
    items_sent = 0;
    held = 1'b0;
    drained = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // idle compare, refused starts, all-high n search, saturating check, all-low p search, high check
    send_beat(CMD_COMPARE, 4'hF, 1'b1);
    send_beat(CMD_START, 4'h0, 1'b0);
    send_beat(CMD_START, 4'hF, 1'b1);
    send_beat(CMD_START, 4'h0, 1'b1);
    repeat (4) send_beat(CMD_COMPARE, 4'hF, 1'b0);
    send_beat(CMD_COMPARE, 4'hF, 1'b1);
    repeat (4) send_beat(CMD_COMPARE, 4'h0, 1'b1);
    send_beat(CMD_COMPARE, 4'hF, 1'b0);
    // mixed bits, p trims held from the last run during the n phases
    send_beat(CMD_START, 4'hA, 1'b1);
    send_beat(CMD_COMPARE, 4'hA, 1'b1);
    send_beat(CMD_COMPARE, 4'h5, 1'b0);
    send_beat(CMD_COMPARE, 4'hA, 1'b1);
    send_beat(CMD_COMPARE, 4'h5, 1'b0);
    send_beat(CMD_COMPARE, 4'h0, 1'b1);
    send_beat(CMD_COMPARE, 4'h5, 1'b1);
    send_beat(CMD_COMPARE, 4'h3, 1'b0);
    send_beat(CMD_COMPARE, 4'hC, 1'b1);
    send_beat(CMD_COMPARE, 4'h9, 1'b0);
    send_beat(CMD_COMPARE, 4'hF, 1'b1);
    drain_results();

    items_sent = 0;
    while (items_sent < 2000) begin
      if (!held && items_sent >= 600) begin
        hold_req = 1'b1;
        fast_left = 150;
        held = 1'b1;
      end
      if (!drained && items_sent >= 1200) begin
        drain_results();
        drained = 1'b1;
      end
      if ($urandom_range(0, 4) == 0) begin
        send_beat(1'($urandom), CMP_W'($urandom), 1'($urandom));
        items_sent--;
      end else begin
        run_calibration();
      end
    end

    drain_results();
    repeat (10) @(posedge clk);
    $display("checked %0d result beats: %0d finished calibrations, %0d refused starts",
             sb.checked, sb.done_seen, sb.err_seen);
    $display("random stalls, a long receiver hold-off and a full drain were covered");
    if (sb.fails == 0 && sb.pending.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/sotc_pkg.sv
rtl/sotc_in_reg.sv
rtl/sotc_step.sv
rtl/sar_offset_trim_calibrator_unit.sv
sim/tb_sar_offset_trim_calibrator_unit.sv
